@@ rtl/sha0_pkg.sv @@
package sha0_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned BLK_WORDS  = 16;
    localparam int unsigned CV_WORDS   = 5;
    localparam int unsigned ROUNDS     = 80;
    localparam int unsigned RND_W      = 7;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned LEN_W      = 64;

    localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUNDS - 1);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(CV_WORDS - 1);
    // word positions that hold the bit length
    localparam logic [POS_W-1:0] LEN_HI_POS = 4'd14;
    localparam logic [POS_W-1:0] LEN_LO_POS = 4'd15;

    localparam logic [WORD_W-1:0] CV_INIT [CV_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [WORD_W-1:0] PAD_FULL = 32'h80000000;

    // working variables of the compression
    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] e;
    } work_t;

    // controls for the block buffer
    typedef struct packed {
        logic              wr_en;    // write word at pos
        logic              fill_en;  // zero every entry above pos
        logic              clr_low;  // zero entries below the length words
        logic              len_en;   // write the bit length into the last two entries
        logic              shift_en; // advance the schedule by one round
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] word;
    } sched_ctl_t;

    // round constant for round t
    function automatic logic [WORD_W-1:0] round_k(input logic [RND_W-1:0] t);
        logic [WORD_W-1:0] k;
        priority if (t < 7'd20) k = 32'h5A827999;
        else if (t < 7'd40)     k = 32'h6ED9EBA1;
        else if (t < 7'd60)     k = 32'h8F1BBCDC;
        else                    k = 32'hCA62C1D6;
        return k;
    endfunction

    // keep the valid high-order bytes, clear the rest, place the 0x80 marker
    function automatic logic [WORD_W-1:0] pad_word(input logic [WORD_W-1:0] data,
                                                   input logic [2:0] nbytes);
        logic [WORD_W-1:0] w;
        unique case (nbytes)
            3'd0:    w = PAD_FULL;
            3'd1:    w = {data[31:24], 24'h800000};
            3'd2:    w = {data[31:16], 16'h8000};
            3'd3:    w = {data[31:8], 8'h80};
            default: w = PAD_FULL;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/sha0_hash_engine.sv @@
// Channel  Direction  Handshake            Payload
// s_       in         s_valid / s_ready    s_data_word, s_valid_bytes, s_last
// m_       out        m_valid / m_ready    m_digest_word, m_word_index, m_final_word
//
// A word that does not complete a block is stored and s_ready stays high. The word that
// fills the block starts a compression (load, 80 rounds on the single round unit,
// feed-forward add).
// A last word adds one padding step and one compression, or two padding steps and
// two compressions when the marker lands in word 14 or 15, then five digest
// transactions gated by m_ready.
// Synchronous active-low reset loads the initial chaining value and zero length.
// s_ready is low while a block compresses or the digest is being delivered.
module sha0_hash_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_valid_bytes,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_final_word
);
    import sha0_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_PAD2,
        ST_OUT
    } state_t;

    state_t            state_reg;
    state_t            ret_reg;
    logic [WORD_W-1:0] cv_reg [CV_WORDS];
    logic [POS_W-1:0]  pos_reg;
    logic [LEN_W-1:0]  bitlen_reg;
    logic [RND_W-1:0]  rnd_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [WORD_W-1:0] pad_reg;
    work_t             work_reg;

    work_t             round_next;
    sched_ctl_t        ctl;
    logic [WORD_W-1:0] wt;
    logic              s_fire;
    logic              m_fire;
    logic [2:0]        nbytes;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign nbytes  = (s_valid_bytes > 3'd4) ? 3'd4 : s_valid_bytes;

    assign m_word_index = idx_reg;
    assign m_final_word = (idx_reg == LAST_IDX);

    // pick the digest word being delivered
    always_comb begin
        unique case (idx_reg)
            3'd0:    m_digest_word = cv_reg[0];
            3'd1:    m_digest_word = cv_reg[1];
            3'd2:    m_digest_word = cv_reg[2];
            3'd3:    m_digest_word = cv_reg[3];
            default: m_digest_word = cv_reg[4];
        endcase
    end

    // drive the block buffer from the sequencer state
    always_comb begin
        ctl          = '0;
        ctl.pos      = pos_reg;
        ctl.word     = s_data_word;
        unique case (state_reg)
            ST_IDLE: begin
                ctl.wr_en = s_fire && (!s_last || nbytes == 3'd4);
            end
            ST_PAD: begin
                ctl.wr_en   = 1'b1;
                ctl.fill_en = 1'b1;
                ctl.word    = pad_reg;
                ctl.len_en  = (pos_reg < LEN_HI_POS);
            end
            ST_PAD2: begin
                ctl.clr_low = 1'b1;
                ctl.len_en  = 1'b1;
            end
            ST_ROUND: begin
                ctl.shift_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    sha0_sched u_sched (
        .aclk    (aclk),
        .ctl     (ctl),
        .bit_len (bitlen_reg),
        .wt      (wt)
    );

    sha0_round u_round (
        .rnd (rnd_reg),
        .cur (work_reg),
        .wt  (wt),
        .nxt (round_next)
    );

    // sequencer: load words, pad, run rounds, deliver the digest
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ret_reg    <= ST_IDLE;
            pos_reg    <= '0;
            bitlen_reg <= '0;
            rnd_reg    <= '0;
            idx_reg    <= '0;
            for (int i = 0; i < CV_WORDS; i++) begin
                cv_reg[i] <= CV_INIT[i];
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (!s_last) begin
                            bitlen_reg <= bitlen_reg + LEN_W'(32);
                            pos_reg    <= pos_reg + 4'd1;
                            if (pos_reg == LEN_LO_POS) begin
                                state_reg <= ST_INIT;
                                ret_reg   <= ST_IDLE;
                            end
                        end else begin
                            bitlen_reg <= bitlen_reg + LEN_W'({nbytes, 3'b000});
                            pad_reg    <= pad_word(s_data_word, nbytes);
                            if (nbytes == 3'd4) begin
                                // full last word: marker opens the next word
                                pos_reg <= pos_reg + 4'd1;
                                if (pos_reg == LEN_LO_POS) begin
                                    state_reg <= ST_INIT;
                                    ret_reg   <= ST_PAD;
                                end else begin
                                    state_reg <= ST_PAD;
                                end
                            end else begin
                                state_reg <= ST_PAD;
                            end
                        end
                    end
                end
                ST_PAD: begin
                    state_reg <= ST_INIT;
                    ret_reg   <= (pos_reg >= LEN_HI_POS) ? ST_PAD2 : ST_OUT;
                end
                ST_PAD2: begin
                    state_reg <= ST_INIT;
                    ret_reg   <= ST_OUT;
                end
                ST_INIT: begin
                    work_reg  <= '{a: cv_reg[0], b: cv_reg[1], c: cv_reg[2],
                                   d: cv_reg[3], e: cv_reg[4]};
                    rnd_reg   <= '0;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    work_reg <= round_next;
                    if (rnd_reg == LAST_ROUND) begin
                        rnd_reg   <= '0;
                        state_reg <= ST_FINAL;
                    end else begin
                        rnd_reg <= rnd_reg + 7'd1;
                    end
                end
                ST_FINAL: begin
                    cv_reg[0] <= cv_reg[0] + work_reg.a;
                    cv_reg[1] <= cv_reg[1] + work_reg.b;
                    cv_reg[2] <= cv_reg[2] + work_reg.c;
                    cv_reg[3] <= cv_reg[3] + work_reg.d;
                    cv_reg[4] <= cv_reg[4] + work_reg.e;
                    rnd_reg   <= '0;
                    state_reg <= ret_reg;
                end
                ST_OUT: begin
                    if (m_fire) begin
                        if (idx_reg == LAST_IDX) begin
                            // restart for the next message
                            idx_reg    <= '0;
                            pos_reg    <= '0;
                            bitlen_reg <= '0;
                            for (int i = 0; i < CV_WORDS; i++) begin
                                cv_reg[i] <= CV_INIT[i];
                            end
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and digest channels active together");

    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rnd_reg <= LAST_ROUND)
        else $error("round counter out of range");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word_index <= LAST_IDX)
        else $error("digest word index out of range");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_final_word) |=> (s_ready && bitlen_reg == '0))
        else $error("engine did not restart after the digest");

    a_block_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_last && pos_reg == LEN_LO_POS) |=> !s_ready)
        else $error("full block did not start a compression");
`endif

endmodule

@@ rtl/sha0_round.sv @@
module sha0_round (
    input  logic [6:0]      rnd,
    input  sha0_pkg::work_t cur,
    input  logic [31:0]     wt,
    output sha0_pkg::work_t nxt
);
    import sha0_pkg::*;

    logic [WORD_W-1:0] f;

    // select the round function by round group
    always_comb begin
        priority if (rnd < 7'd20) begin
            f = cur.d ^ (cur.b & (cur.c ^ cur.d));
        end else if (rnd < 7'd40 || rnd >= 7'd60) begin
            f = cur.b ^ cur.c ^ cur.d;
        end else begin
            f = (cur.b & cur.c) | (cur.d & (cur.b | cur.c));
        end
    end

    // one round: new a from the five-operand sum, rotate the rest down
    always_comb begin
        nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + round_k(rnd) + wt;
        nxt.b = cur.a;
        nxt.c = {cur.b[1:0], cur.b[31:2]};
        nxt.d = cur.c;
        nxt.e = cur.d;
    end

endmodule

@@ rtl/sha0_sched.sv @@
module sha0_sched (
    input  logic                 aclk,
    input  sha0_pkg::sched_ctl_t ctl,
    input  logic [63:0]          bit_len,
    output logic [31:0]          wt
);
    import sha0_pkg::*;

    logic [WORD_W-1:0] buf_reg [BLK_WORDS];
    logic [WORD_W-1:0] expand;

    // W[t+16] from the taps at t, t+2, t+8 and t+13 (no rotation)
    assign expand = buf_reg[13] ^ buf_reg[8] ^ buf_reg[2] ^ buf_reg[0];
    assign wt     = buf_reg[0];

    // load words, pad, or advance the schedule line
    always_ff @(posedge aclk) begin
        if (ctl.shift_en) begin
            for (int i = 0; i < BLK_WORDS - 1; i++) begin
                buf_reg[i] <= buf_reg[i + 1];
            end
            buf_reg[BLK_WORDS - 1] <= expand;
        end else begin
            for (int i = 0; i < BLK_WORDS; i++) begin
                // length words win over the zero fill
                priority if (ctl.len_en && POS_W'(i) == LEN_HI_POS) begin
                    buf_reg[i] <= bit_len[63:32];
                end else if (ctl.len_en && POS_W'(i) == LEN_LO_POS) begin
                    buf_reg[i] <= bit_len[31:0];
                end else if (ctl.wr_en && ctl.pos == POS_W'(i)) begin
                    buf_reg[i] <= ctl.word;
                end else if (ctl.fill_en && POS_W'(i) > ctl.pos) begin
                    buf_reg[i] <= '0;
                end else if (ctl.clr_low && POS_W'(i) < LEN_HI_POS) begin
                    buf_reg[i] <= '0;
                end else begin
                    buf_reg[i] <= buf_reg[i];
                end
            end
        end
    end

endmodule

@@ sim/sha0_hash_engine_test.sv @@
module sha0_hash_engine_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIMIT_CYCLES = 300000;
    localparam int unsigned TAIL_CYCLES  = 200;
    localparam int unsigned WORD_TARGET  = 430;
    localparam int unsigned IDLE_PCT     = 27;
    localparam int unsigned HOLD_AT      = 60;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned QUIET_FROM   = 200;
    localparam int unsigned QUIET_TO     = 300;
    localparam int unsigned DIGEST_WORDS = 5;

    localparam logic [31:0] K_CHOOSE   = 32'h5A827999;
    localparam logic [31:0] K_PARITY_A = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
    localparam logic [31:0] K_PARITY_B = 32'hCA62C1D6;
    localparam logic [31:0] CV_START [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [31:0] PAD_MARK_FULL = 32'h80000000;
    localparam logic [31:0] PAD_BYTE      = 32'h00000080;
    localparam logic [2:0]  FULL_BYTES    = 3'd4;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
        logic        wait_drain;
    } msg_word_t;

    typedef struct packed {
        logic [31:0] digest;
        logic [2:0]  position;
        logic        closing;
    } digest_beat_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [31:0] s_data_word   = '0;
    logic [2:0]  s_valid_bytes = '0;
    logic        s_last        = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_final_word;

    sha0_hash_engine uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_word   (s_data_word),
        .s_valid_bytes (s_valid_bytes),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_final_word  (m_final_word)
    );

    msg_word_t    word_queue[$];
    digest_beat_t digest_expect[$];

    // hash state mirrored from the accepted words
    logic [31:0] cv_state  [5];
    logic [31:0] blk_state [16];
    logic [3:0]  wpos_state;
    logic [63:0] nbits_state;

    int unsigned total_words    = 0;
    int unsigned items_accepted = 0;
    int unsigned beats_pushed   = 0;
    int unsigned beats_seen     = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;
    int unsigned hold_left      = 0;
    logic        hold_done      = 1'b0;

    wire quiet_window = (items_accepted >= QUIET_FROM) && (items_accepted < QUIET_TO);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // SHA-0 compression of the block buffer into the chaining value
    function automatic void hash_compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        int t;
        for (t = 0; t < 16; t++) w[t] = blk_state[t];
        a = cv_state[0];
        b = cv_state[1];
        c = cv_state[2];
        d = cv_state[3];
        e = cv_state[4];
        for (t = 0; t < 80; t++) begin
            // expand in place, no rotation in this schedule
            if (t >= 16) begin
                w[t % 16] = w[t % 16] ^ w[(t + 2) % 16] ^ w[(t + 8) % 16]
                            ^ w[(t + 13) % 16];
            end
            if (t < 20) begin
                f = d ^ (b & (c ^ d));
                k = K_CHOOSE;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_PARITY_A;
            end else if (t < 60) begin
                f = (b & c) | (d & (b | c));
                k = K_MAJORITY;
            end else begin
                f = b ^ c ^ d;
                k = K_PARITY_B;
            end
            tmp = {a[26:0], a[31:27]} + f + e + k + w[t % 16];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        cv_state[0] = cv_state[0] + a;
        cv_state[1] = cv_state[1] + b;
        cv_state[2] = cv_state[2] + c;
        cv_state[3] = cv_state[3] + d;
        cv_state[4] = cv_state[4] + e;
    endfunction

    function automatic void hash_restart();
        int i;
        for (i = 0; i < 5; i++) cv_state[i] = CV_START[i];
        wpos_state  = '0;
        nbits_state = '0;
    endfunction

    function automatic void hash_absorb_word(input logic [31:0] data);
        blk_state[wpos_state] = data;
        wpos_state = wpos_state + 4'd1;
        if (wpos_state == 4'd0) hash_compress_block();
    endfunction

    // pad, append the length, emit the digest words and start over
    function automatic void hash_finish_message(input logic [31:0] data,
                                                input logic [2:0] nbytes_in);
        logic [31:0]  padw, keep;
        int           nb, p, i;
        digest_beat_t beat;
        nb = (nbytes_in > FULL_BYTES) ? 4 : int'(nbytes_in);
        nbits_state = nbits_state + 64'(8 * nb);
        if (nb == 4) begin
            hash_absorb_word(data);
            padw = PAD_MARK_FULL;
        end else begin
            keep = (nb == 0) ? '0 : (32'hFFFFFFFF << (32 - 8 * nb));
            padw = (data & keep) | (PAD_BYTE << (24 - 8 * nb));
        end
        p = int'(wpos_state);
        blk_state[p] = padw;
        for (i = p + 1; i < 16; i++) blk_state[i] = '0;
        // marker in the length words: spill into one more block
        if (p >= 14) begin
            hash_compress_block();
            for (i = 0; i < 14; i++) blk_state[i] = '0;
        end
        blk_state[14] = nbits_state[63:32];
        blk_state[15] = nbits_state[31:0];
        hash_compress_block();
        for (i = 0; i < DIGEST_WORDS; i++) begin
            beat.digest   = cv_state[i];
            beat.position = 3'(i);
            beat.closing  = (i == DIGEST_WORDS - 1);
            digest_expect.push_back(beat);
        end
        hash_restart();
    endfunction

    task automatic queue_word(input logic [31:0] data, input logic [2:0] nbytes,
                              input logic last, input logic wait_drain);
        msg_word_t item;
        item.data       = data;
        item.nbytes     = nbytes;
        item.last       = last;
        item.wait_drain = wait_drain;
        word_queue.push_back(item);
    endtask

    // full words with random data, then a closing word
    task automatic queue_message(input int n_full, input logic [2:0] last_bytes,
                                 input logic wait_drain);
        int i;
        for (i = 0; i < n_full; i++) begin
            queue_word($urandom, 3'($urandom_range(0, 7)), 1'b0, wait_drain && (i == 0));
        end
        queue_word($urandom, last_bytes, 1'b1, wait_drain && (n_full == 0));
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] digest mismatch on %s: got %h, want %h", $realtime, what,
                 got, want);
        mismatches++;
    endtask

    // input driver: present queued words, predict on each accepted transaction
    always @(posedge aclk) begin : drive_words
        int unsigned pushed_next;
        logic        go;
        msg_word_t   nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            hash_restart();
            for (int i = 0; i < 16; i++) blk_state[i] = '0;
        end else begin
            pushed_next = beats_pushed;
            if (s_valid && s_ready) begin
                if (s_last) begin
                    hash_finish_message(s_data_word, s_valid_bytes);
                    pushed_next = beats_pushed + DIGEST_WORDS;
                end else begin
                    nbits_state = nbits_state + 64'd32;
                    hash_absorb_word(s_data_word);
                end
                items_accepted <= items_accepted + 1;
                beats_pushed   <= pushed_next;
            end
            if (!s_valid || s_ready) begin
                go = (word_queue.size() != 0);
                // hold a draining word until every digest word has come back
                if (go && word_queue[0].wait_drain && pushed_next != beats_seen) go = 1'b0;
                if (go && !quiet_window && $urandom_range(0, 99) < IDLE_PCT) go = 1'b0;
                if (go) begin
                    nxt = word_queue.pop_front();
                    s_valid       <= 1'b1;
                    s_data_word   <= nxt.data;
                    s_valid_bytes <= nxt.nbytes;
                    s_last        <= nxt.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver pacing, with one long hold-off once the random part is running
    always @(posedge aclk) begin : pace_digest
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_accepted >= HOLD_AT) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= quiet_window || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // compare each digest transaction with the oldest expectation
    always @(posedge aclk) begin : check_digest
        digest_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_seen <= beats_seen + 1;
            if (digest_expect.size() == 0) begin
                report_mismatch("unexpected transaction", m_digest_word, '0);
            end else begin
                want = digest_expect.pop_front();
                if (m_digest_word !== want.digest)
                    report_mismatch("digest_word", m_digest_word, want.digest);
                if (m_word_index !== want.position)
                    report_mismatch("word_index", 32'(m_word_index), 32'(want.position));
                if (m_final_word !== want.closing)
                    report_mismatch("final_word", 32'(m_final_word), 32'(want.closing));
            end
        end
    end

    // abort a hung run
    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("sha0_hash_engine verification failed");
            $finish;
        end
    end

    initial begin : run_sequence
        int r, n;
        // directed: empty message, each partial length, full and oversized counts
        queue_word(32'hFFFFFFFF, 3'd0, 1'b1, 1'b0);
        queue_word(32'hFFFFFFFF, 3'd1, 1'b1, 1'b0);
        queue_word(32'h12345678, 3'd2, 1'b1, 1'b0);
        queue_word(32'hA5A5A5A5, 3'd3, 1'b1, 1'b0);
        queue_word(32'h00000000, 3'd4, 1'b1, 1'b0);
        queue_word(32'hFFFFFFFF, 3'd7, 1'b1, 1'b1);
        // full closing word that fills the block: marker opens a fresh block
        queue_word(32'hFFFFFFFF, 3'd0, 1'b0, 1'b1);
        for (int i = 0; i < 14; i++) queue_word($urandom, 3'($urandom_range(0, 7)), 1'b0, 1'b0);
        queue_word(32'h00000000, 3'd4, 1'b1, 1'b0);

        // random messages, mostly short, some spanning several blocks
        while (word_queue.size() < WORD_TARGET) begin
            r = $urandom_range(0, 9);
            n = (r < 7) ? $urandom_range(0, 20) : $urandom_range(21, 64);
            queue_message(n, 3'($urandom_range(0, 7)), ($urandom_range(0, 9) == 0));
        end
        total_words = word_queue.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_accepted != total_words || digest_expect.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (mismatches == 0 && digest_expect.size() == 0) begin
            $display("sha0_hash_engine verification clean");
        end else begin
            $display("sha0_hash_engine verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/sha0_pkg.sv
rtl/sha0_round.sv
rtl/sha0_sched.sv
rtl/sha0_hash_engine.sv
sim/sha0_hash_engine_test.sv
